// ----- hdl/sobel_edge_magnitude_3x3_top_assert.svh -----
// ---------------------------------------------------------------------------
// Sobel edge magnitude: assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SEM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sem: same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sem: next-cycle check failed");

`endif

// ----- hdl/sem_pkg.sv -----
// ---------------------------------------------------------------------------
// sem_pkg
// Shared constants, types and square-root step function.
// ---------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 11;
    localparam int CTR_W  = 10;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CMP_W  = ((DIM_W > COL_W) ? DIM_W : COL_W) + 1;
    localparam int RAM_W  = 2 * PIX_W;

    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // signed gradient before the quarter scaling: +/-1020
    localparam int GRAD_W = 11;
    localparam int SQR_W  = 2 * PIX_W;
    localparam int SUM_W  = SQR_W + 1;

    // radicand below 2^17; root stepped two bits at a time from bit 16
    localparam int SQ_W       = SUM_W + 1;
    localparam int SQRT_STEPS = 3;
    localparam int SQRT_TOP_A = 16;
    localparam int SQRT_TOP_B = SQRT_TOP_A - 2 * SQRT_STEPS;
    localparam int SQRT_TOP_C = SQRT_TOP_B - 2 * SQRT_STEPS;
    localparam int EDGE_MAX   = 255;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [CTR_W-1:0] col;
        logic [CTR_W-1:0] row;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] ax;
        logic [PIX_W-1:0] ay;
        tag_t             tag;
    } grad_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    // three restoring steps of the digit-pair integer square root
    function automatic sqrt_t sqrt_steps(input sqrt_t s_in, input int top_bit);
        sqrt_t           s;
        logic [SQ_W-1:0] bit_v;
        logic [SQ_W-1:0] trial;
        s = s_in;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            bit_v = SQ_W'(1) << (top_bit - 2 * i);
            trial = s.root + bit_v;
            if (s.rem >= trial)
            begin
                s.rem  = s.rem - trial;
                s.root = (s.root >> 1) + bit_v;
            end
            else
            begin
                s.root = s.root >> 1;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sobel_edge_magnitude_3x3_top.sv -----
// Path: a pixel that completes a 3x3 window passes the gradient register and then
//   the squares, sum, root A, root B and root C stages before out_valid shows it.
// Throughput: one pixel per clock unless out_stall backs up, as set by the line
//   store's read and write per cycle; each result stage moves once the next frees.
// Reset: counters, window and pipeline valids clear, size registers go to 640x480;
//   the line store is not cleared and holds garbage until written.
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_top
// 3x3 Sobel edge magnitude over a raster grayscale stream.
// ---------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_3x3_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration write port
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [sem_pkg::DIM_W-1:0]   cfg_data,
    // pixel input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [sem_pkg::PIX_W-1:0]   pixel_value,
    // edge result channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [sem_pkg::PIX_W-1:0]        edge_value,
    output logic [sem_pkg::CTR_W-1:0]        center_col,
    output logic [sem_pkg::CTR_W-1:0]        center_row,
    output logic                             frame_last
);

    // Frame size registers keep the clamped value, so the datapath only
    // ever sees a legal size (3 up to the line-store depth / frame limit).
    logic [sem_pkg::DIM_W-1:0] width_reg, width_next;
    logic [sem_pkg::DIM_W-1:0] height_reg, height_next;

    logic           grad_valid;
    logic           grad_take;
    sem_pkg::grad_t grad;

    function automatic logic [sem_pkg::DIM_W-1:0] clamp_dim(
        input logic [sem_pkg::DIM_W-1:0] v,
        input logic [sem_pkg::DIM_W-1:0] maxv
    );
        logic [sem_pkg::DIM_W-1:0] r;
        r = v;
        if (v < sem_pkg::DIM_W'(3))
        begin
            r = sem_pkg::DIM_W'(3);
        end
        else if (v > maxv)
        begin
            r = maxv;
        end
        return r;
    endfunction

    // Writes take effect at once; counters keep running and wrap at the
    // next advance if they already sit past the new limit.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (sem_pkg::cfg_idx_t'(cfg_index))
                sem_pkg::CFG_WIDTH:
                begin
                    width_next = clamp_dim(cfg_data, sem_pkg::DIM_W'(sem_pkg::MAX_WIDTH));
                end
                sem_pkg::CFG_HEIGHT:
                begin
                    height_next = clamp_dim(cfg_data, sem_pkg::DIM_W'(sem_pkg::MAX_HEIGHT));
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sem_pkg::DIM_W'(sem_pkg::WIDTH_RST);
            height_reg <= sem_pkg::DIM_W'(sem_pkg::HEIGHT_RST);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Front end: raster position, two-row line store (older/newer packed in
    // one word, read-ahead one column), window shift and quarter gradients.
    sem_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .img_w      (width_reg),
        .img_h      (height_reg),
        .pix_valid  (in_valid),
        .pix        (pixel_value),
        .pix_stall  (in_stall),
        .grad_valid (grad_valid),
        .grad       (grad),
        .grad_take  (grad_take)
    );

    // Back end: squares, sum, three root stages; last stage is the output
    // register, so a waiting result stalls only the run of full stages behind it.
    sem_mag u_mag (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (grad_valid),
        .grad       (grad),
        .grad_take  (grad_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .edge_value (edge_value),
        .center_col (center_col),
        .center_row (center_row),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire

// ----- hdl/sem_line_ram.sv -----
// ---------------------------------------------------------------------------
// sem_line_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sem_line_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/sem_window.sv -----
// ---------------------------------------------------------------------------
// sem_window
// Raster counters, line store, 3x3 window and quarter gradients.
// ---------------------------------------------------------------------------
`default_nettype none

module sem_window (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [sem_pkg::DIM_W-1:0]   img_w,
    input  wire logic [sem_pkg::DIM_W-1:0]   img_h,
    input  wire logic                        pix_valid,
    input  wire logic [sem_pkg::PIX_W-1:0]   pix,
    output logic                             pix_stall,
    output logic                             grad_valid,
    output sem_pkg::grad_t                   grad,
    input  wire logic                        grad_take
);

    localparam int PW = sem_pkg::PIX_W;
    localparam int GW = sem_pkg::GRAD_W;
    localparam int CW = sem_pkg::CMP_W;

    logic [sem_pkg::COL_W-1:0] col_reg, col_next;
    logic [sem_pkg::ROW_W-1:0] row_reg, row_next;
    logic [PW-1:0]             win_reg [6];
    logic                      vld_reg, vld_next;
    sem_pkg::grad_t            grad_reg, grad_next;

    logic                      take, accept;
    logic                      full, last, col_wrap, row_wrap;
    logic [sem_pkg::RAM_W-1:0] rd;
    logic [sem_pkg::COL_W-1:0] raddr;
    logic [PW-1:0]             top, mid;
    logic signed [GW-1:0]      gx, gy;

    function automatic logic signed [GW-1:0] ext8(input logic [PW-1:0] p);
        return $signed({{(GW-PW){1'b0}}, p});
    endfunction

    // divide by 4 toward zero, then magnitude (at most 255)
    function automatic logic [PW-1:0] qabs(input logic signed [GW-1:0] g);
        logic signed [GW-1:0] q;
        q = g[GW-1] ? ((g + GW'(3)) >>> 2) : (g >>> 2);
        q = q[GW-1] ? -q : q;
        return q[PW-1:0];
    endfunction

    // stage accepts when empty or when its result moves on
    assign take      = !vld_reg || grad_take;
    assign pix_stall = !take;
    assign accept    = pix_valid && take;

    assign top = rd[2*PW-1:PW];
    assign mid = rd[PW-1:0];

    always_comb
    begin
        full = (col_reg >= sem_pkg::COL_W'(2)) && (CW'(col_reg) < CW'(img_w))
            && (row_reg >= sem_pkg::ROW_W'(2)) && (CW'(row_reg) < CW'(img_h));
        last = (CW'(col_reg) + CW'(1) == CW'(img_w))
            && (CW'(row_reg) + CW'(1) == CW'(img_h));
        col_wrap = (CW'(col_reg) + CW'(1)) >= CW'(img_w);
        row_wrap = (CW'(row_reg) + CW'(1)) >= CW'(img_h);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + sem_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + sem_pkg::COL_W'(1);
            end
        end
        // fetch the column the next pixel will use
        raddr = col_next;
    end

    always_comb
    begin
        gx = (ext8(win_reg[0]) - ext8(top))
           + ((ext8(win_reg[1]) - ext8(mid)) <<< 1)
           + (ext8(win_reg[2]) - ext8(pix));
        gy = (ext8(win_reg[2]) + (ext8(win_reg[5]) <<< 1) + ext8(pix))
           - (ext8(win_reg[0]) + (ext8(win_reg[3]) <<< 1) + ext8(top));

        grad_next          = grad_reg;
        grad_next.ax       = qabs(gx);
        grad_next.ay       = qabs(gy);
        grad_next.tag.col  = sem_pkg::CTR_W'(col_reg - sem_pkg::COL_W'(1));
        grad_next.tag.row  = sem_pkg::CTR_W'(row_reg - sem_pkg::ROW_W'(1));
        grad_next.tag.last = last;

        vld_next = vld_reg;
        if (take)
        begin
            vld_next = accept && full;
        end
    end

    sem_line_ram #(
        .DATA_W (sem_pkg::RAM_W),
        .ADDR_W (sem_pkg::COL_W)
    ) u_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata ({mid, pix}),
        .raddr (raddr),
        .rdata (rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            vld_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            vld_reg <= vld_next;
            if (accept)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grad_reg <= grad_next;
        end
    end

    assign grad_valid = vld_reg;
    assign grad       = grad_reg;

endmodule

`default_nettype wire

// ----- hdl/sem_mag.sv -----
// ---------------------------------------------------------------------------
// sem_mag
// Squares, sum and pipelined integer square root with saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module sem_mag (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        grad_valid,
    input  sem_pkg::grad_t                   grad,
    output logic                             grad_take,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [sem_pkg::PIX_W-1:0]        edge_value,
    output logic [sem_pkg::CTR_W-1:0]        center_col,
    output logic [sem_pkg::CTR_W-1:0]        center_row,
    output logic                             frame_last
);

    localparam int NS = 5;
    localparam int SQW = sem_pkg::SQ_W;

    logic [NS-1:0]               vld_reg, vld_next;
    logic [NS-1:0]               take;
    sem_pkg::tag_t               tag_reg [NS];
    logic [sem_pkg::SQR_W-1:0]   sqx_reg, sqy_reg;
    sem_pkg::sqrt_t              s1_reg, s2_reg, s3_reg;
    sem_pkg::sqrt_t              s1_next, s2_next, s3_next, s4_val;
    logic [sem_pkg::PIX_W-1:0]   edge_reg, edge_next;

    // stage order: squares, sum, root A, root B, root C + clip (output)
    always_comb
    begin
        take[NS-1] = !vld_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            take[k] = !vld_reg[k] || take[k+1];
        end
        vld_next = vld_reg;
        if (take[0])
        begin
            vld_next[0] = grad_valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (take[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    assign grad_take = take[0];

    always_comb
    begin
        s1_next.rem  = SQW'(sem_pkg::SUM_W'(sqx_reg) + sem_pkg::SUM_W'(sqy_reg));
        s1_next.root = '0;
        s2_next      = sem_pkg::sqrt_steps(s1_reg, sem_pkg::SQRT_TOP_A);
        s3_next      = sem_pkg::sqrt_steps(s2_reg, sem_pkg::SQRT_TOP_B);
        s4_val       = sem_pkg::sqrt_steps(s3_reg, sem_pkg::SQRT_TOP_C);
        edge_next    = (s4_val.root > SQW'(sem_pkg::EDGE_MAX))
                     ? sem_pkg::PIX_W'(sem_pkg::EDGE_MAX)
                     : s4_val.root[sem_pkg::PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take[0])
        begin
            sqx_reg    <= {{sem_pkg::PIX_W{1'b0}}, grad.ax} * {{sem_pkg::PIX_W{1'b0}}, grad.ax};
            sqy_reg    <= {{sem_pkg::PIX_W{1'b0}}, grad.ay} * {{sem_pkg::PIX_W{1'b0}}, grad.ay};
            tag_reg[0] <= grad.tag;
        end
        if (take[1])
        begin
            s1_reg     <= s1_next;
            tag_reg[1] <= tag_reg[0];
        end
        if (take[2])
        begin
            s2_reg     <= s2_next;
            tag_reg[2] <= tag_reg[1];
        end
        if (take[3])
        begin
            s3_reg     <= s3_next;
            tag_reg[3] <= tag_reg[2];
        end
        if (take[4])
        begin
            edge_reg   <= edge_next;
            tag_reg[4] <= tag_reg[3];
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign edge_value = edge_reg;
    assign center_col = tag_reg[NS-1].col;
    assign center_row = tag_reg[NS-1].row;
    assign frame_last = tag_reg[NS-1].last;

endmodule

`default_nettype wire

// ----- hdl/sem_checker.sv -----
// ---------------------------------------------------------------------------
// sem_checker
// Port-level checks for the Sobel edge block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sobel_edge_magnitude_3x3_top_assert.svh"

module sem_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [sem_pkg::PIX_W-1:0]   edge_value,
    input wire logic [sem_pkg::CTR_W-1:0]   center_col,
    input wire logic [sem_pkg::CTR_W-1:0]   center_row,
    input wire logic                        frame_last
);

    // a stalled result stays and keeps its payload
    `SEM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(edge_value) && $stable(center_col) && $stable(center_row) && $stable(frame_last))

    // with the output register empty the whole pipe has room
    `SEM_ASSERT_IMPLY(a_no_false_stall, !out_valid, !in_stall)

    // no result is ever centered on the left or top border (column 0 or row 0)
    `SEM_ASSERT_IMPLY(a_no_border, out_valid, center_col != '0 && center_row != '0)

    // input can only stall while a result is held back
    `SEM_ASSERT_IMPLY(a_stall_cause, in_valid && in_stall, out_valid && out_stall)

endmodule

bind sobel_edge_magnitude_3x3_top sem_checker u_sem_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_value (edge_value),
    .center_col (center_col),
    .center_row (center_row),
    .frame_last (frame_last)
);

`default_nettype wire

// ----- bench/sobel_edge_magnitude_3x3_top_test.sv -----
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_3x3_top_test
// Streams grayscale frames through the Sobel edge block under random
// valid/stall gaps and compares every edge result, field by field, against
// an in-bench model of line stores, window and magnitude math or a pinned result.
// ---------------------------------------------------------------------------

module sobel_edge_magnitude_3x3_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import sem_pkg::*;

    // run shape
    localparam int RAND_PIXELS  = 1650;     // random part runs until at least this many pixels
    localparam int LONG_HOLD    = 400;      // one long output back-pressure stretch
    localparam int DRAIN_CYCLES = 20;       // covers the pipeline depth, with margin on top
    localparam int SETTLE_LIMIT = 20000;    // cycles to wait for outstanding results
    localparam int REPORT_MAX   = 10;

    // one edge result as seen on the output port
    typedef struct packed {
        logic [7:0] mag;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } mag_rec_t;

    // directed stimulus row; pinned rows carry a hand-computed result
    typedef struct packed {
        logic [7:0] pix;
        logic       pinned;
        mag_rec_t   res;
    } pin_row_t;

    typedef enum int {
        STYLE_NOISE,    // full-range random
        STYLE_FAINT,    // tiny values, gradients land on the /4 truncation
        STYLE_BILEVEL,  // 0/255 only, drives saturation
        STYLE_RAMP      // sloped plane plus a little noise
    } pix_style_t;

    localparam mag_rec_t NO_MAG = '0;
    localparam mag_rec_t MAG_255_CTR = '{8'd255, 10'd1, 10'd1, 1'b1};
    localparam mag_rec_t MAG_1_CTR   = '{8'd1,   10'd1, 10'd1, 1'b1};

    // Three 3x3 frames; only the ninth pixel of each completes a window.
    localparam pin_row_t PIN_TAB [27] = '{
        // bright top row, dark below: gy = -1020/4, exactly 255
        '{8'd255, 1'b0, NO_MAG}, '{8'd255, 1'b0, NO_MAG}, '{8'd255, 1'b0, NO_MAG},
        '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG},
        '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b1, MAG_255_CTR},
        // bright left column and bottom row: 191/191 -> 270, clipped to 255
        '{8'd255, 1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG},
        '{8'd255, 1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG},
        '{8'd255, 1'b0, NO_MAG}, '{8'd255, 1'b0, NO_MAG}, '{8'd255, 1'b1, MAG_255_CTR},
        // single 3 at mid-right: gx = -6 truncates to -1, not -2
        '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG},
        '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd3,   1'b0, NO_MAG},
        '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b0, NO_MAG}, '{8'd0,   1'b1, MAG_1_CTR}
    };

    // -----------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // -----------------------------------------------------------------------
    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    logic [0:0]       cfg_index   = '0;
    logic [DIM_W-1:0] cfg_data    = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    logic [7:0]       pixel_value = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    logic [7:0]       edge_value;
    logic [9:0]       center_col;
    logic [9:0]       center_row;
    logic             frame_last;

    sobel_edge_magnitude_3x3_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .edge_value  (edge_value),
        .center_col  (center_col),
        .center_row  (center_row),
        .frame_last  (frame_last)
    );

    // -----------------------------------------------------------------------
    // Model of the block: size registers, two row histories, the 2x3 window
    // and the raster counters. Advanced once per accepted pixel transfer.
    // -----------------------------------------------------------------------
    logic [10:0] width_reg  = 11'd640;
    logic [10:0] height_reg = 11'd480;
    logic [7:0]  hist_older [0:1023];   // row r-2
    logic [7:0]  hist_newer [0:1023];   // row r-1
    logic [7:0]  win [0:5];             // col c-2 top..bottom, col c-1 top..bottom
    int          col_cnt    = 0;
    int          row_cnt    = 0;

    mag_rec_t    pending_edges [$];     // results owed by the block, oldest first

    // bookkeeping
    int  mismatches    = 0;
    int  results_seen  = 0;
    int  pix_count     = 0;
    int  frames_done   = 0;
    int  size_settings = 0;
    int  in_held       = 0;         // cycles with a pixel offered and input stalled
    bit  sender_quiet  = 1'b0;      // no gaps between pixel transfers
    bit  sink_quiet    = 1'b0;      // no stalls on the result side
    bit  long_hold_req = 1'b0;      // asks the result sink for one long hold-off
    int  ramp_dx       = 1;
    int  ramp_dy       = 1;

    initial
    begin
        for (int i = 0; i < 1024; i++)
        begin
            hist_older[i] = '0;
            hist_newer[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
    end

    function automatic int clamp_dim(input logic [10:0] v);
        if (v < 11'd3)
            return 3;
        if (v > 11'd1024)
            return 1024;
        return int'(v);
    endfunction

    // bitwise search for the largest r with r*r <= v
    function automatic int floor_root(input int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = 9; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return int'(r);
    endfunction

    // Consumes one pixel; returns 1 and fills res when a full window is centered.
    function automatic bit sobel_predict(input logic [7:0] pix, output mag_rec_t res);
        int w;
        int h;
        int col;
        int row;
        int top;
        int mid;
        int bot;
        int a0, a1, a2, b0, b1, b2;
        int gx;
        int gy;
        int m;
        bit hit;
        w   = clamp_dim(width_reg);
        h   = clamp_dim(height_reg);
        col = col_cnt;
        row = row_cnt;
        top = int'(hist_older[col % 1024]);
        mid = int'(hist_newer[col % 1024]);
        bot = int'(pix);
        a0  = int'(win[0]);
        a1  = int'(win[1]);
        a2  = int'(win[2]);
        b0  = int'(win[3]);
        b1  = int'(win[4]);
        b2  = int'(win[5]);
        hit = 1'b0;
        res = '0;
        if (col >= 2 && col < w && row >= 2 && row < h)
        begin
            gx = (a0 - top) + 2 * (a1 - mid) + (a2 - bot);
            gy = (a2 + 2 * b2 + bot) - (a0 + 2 * b0 + top);
            gx = gx / 4;        // SV int division truncates toward zero
            gy = gy / 4;
            m  = floor_root(int'(gx * gx + gy * gy));
            res.mag  = (m > 255) ? 8'd255 : 8'(m);
            res.col  = 10'(col - 1);
            res.row  = 10'(row - 1);
            res.last = (col == w - 1 && row == h - 1);
            hit = 1'b1;
        end
        // shift window, then push the new column into the row histories
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = 8'(top);
        win[4] = 8'(mid);
        win[5] = pix;
        hist_older[col % 1024] = 8'(mid);
        hist_newer[col % 1024] = pix;
        if (col + 1 >= w)
        begin
            col_cnt = 0;
            if (row + 1 >= h)
            begin
                row_cnt = 0;
                frames_done++;
            end
            else
                row_cnt = row + 1;
        end
        else
            col_cnt = col + 1;
        return hit;
    endfunction

    // -----------------------------------------------------------------------
    // Clock, reset, watchdog
    // -----------------------------------------------------------------------
    always #5 clk = ~clk;

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Worst case is over 9.3k pixels, each at the largest gap, stall and pipeline
    // delay, plus the long hold; the watchdog time leaves several times that.
    initial
    begin : watchdog
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result side: stall for a drawn number of cycles before each transfer.
    // Quiet stretches (no stalls) are redrawn every 64 results. On request,
    // one long hold lets the pipeline back up into the input.
    // -----------------------------------------------------------------------
    initial
    begin : result_sink
        int hold;
        int served;
        served = 0;
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else
                hold = sink_quiet ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            served++;
            if (served % 64 == 0)
                sink_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // -----------------------------------------------------------------------
    // Result check: every output transfer is matched to the oldest owed result.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        mag_rec_t got;
        mag_rec_t want;
        if (rst_n && in_valid && in_stall)
            in_held++;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mag  = edge_value;
            got.col  = center_col;
            got.row  = center_row;
            got.last = frame_last;
            results_seen++;
            if (pending_edges.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("%0t unexpected result: mag %0d col %0d row %0d last %0b",
                             $realtime, got.mag, got.col, got.row, got.last);
                mismatches++;
            end
            else
            begin
                want = pending_edges.pop_front();
                if (got !== want)
                begin
                    if (mismatches < REPORT_MAX)
                        $display({"%0t result mismatch: exp mag %0d col %0d row %0d last %0b,",
                                  " got mag %0d col %0d row %0d last %0b"},
                                 $realtime, want.mag, want.col, want.row, want.last,
                                 got.mag, got.col, got.row, got.last);
                    mismatches++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // One pixel transfer. Pinned rows supply their own expected result.
    task automatic push_pixel(input logic [7:0] pix, input bit pinned,
                              input mag_rec_t pinned_res);
        int       idle;
        bit       hit;
        mag_rec_t res;
        idle = sender_quiet ? 0 : $urandom_range(0, 18);
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_value <= pix;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        hit = sobel_predict(pix, res);
        if (pinned)
            pending_edges.push_back(pinned_res);
        else if (hit)
            pending_edges.push_back(res);
        pix_count++;
    endtask

    function automatic logic [7:0] next_pixel(input pix_style_t style);
        case (style)
            STYLE_FAINT:   return 8'($urandom_range(0, 7));
            STYLE_BILEVEL: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            STYLE_RAMP:    return 8'(col_cnt * ramp_dx + row_cnt * ramp_dy
                                     + $urandom_range(0, 3));
            default:       return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic stream_pixels(input int n, input pix_style_t style);
        for (int i = 0; i < n; i++)
            push_pixel(next_pixel(style), 1'b0, NO_MAG);
    endtask

    // runs until the raster counters are back at the top-left corner
    task automatic finish_frame(input pix_style_t style);
        do
        begin
            push_pixel(next_pixel(style), 1'b0, NO_MAG);
        end
        while (col_cnt != 0 || row_cnt != 0);
    endtask

    // Block idle: all owed results back, then a pipeline's worth of cycles
    // for pixels that never make a result. Missing results count as failures.
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (pending_edges.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_edges.size() != 0)
        begin
            if (mismatches < REPORT_MAX)
                $display("%0t %0d results never arrived, oldest col %0d row %0d",
                         $realtime, pending_edges.size(),
                         pending_edges[0].col, pending_edges[0].row);
            mismatches += pending_edges.size();
            pending_edges.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write strobe is one cycle, followed by a quiet gap so back-to-back
    // writes never drop and raise cfg_we in the same step.
    task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(posedge clk);
    endtask

    // the minimum size is often written below range to hit the clamp
    function automatic logic [10:0] raw_dim(input int d);
        if (d == 3)
            return 11'($urandom_range(0, 3));
        return 11'(d);
    endfunction

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        int         w;
        int         h;
        int         rand_start;
        pix_style_t style;

        wait (rst_n);
        @(posedge clk);

        // Height left at its reset value: a 3-wide, 480-tall frame.
        write_reg(CFG_WIDTH, 11'd3);
        finish_frame(STYLE_NOISE);
        size_settings++;

        // Directed 3x3 frames, size written below range on both registers.
        settle();
        write_reg(CFG_WIDTH, 11'd2);
        write_reg(CFG_HEIGHT, 11'd0);
        foreach (PIN_TAB[i])
            push_pixel(PIN_TAB[i].pix, PIN_TAB[i].pinned, PIN_TAB[i].res);
        size_settings++;

        // Widest frame (all-ones width clamps to 1024), three rows, gapless
        // input while the result side holds off once for a long stretch.
        settle();
        write_reg(CFG_WIDTH, 11'h7FF);
        write_reg(CFG_HEIGHT, 11'd3);
        sender_quiet  = 1'b1;
        long_hold_req = 1'b1;
        finish_frame(STYLE_BILEVEL);
        sender_quiet  = 1'b0;
        size_settings++;

        // Tallest frame: 3 wide, height just above range clamps to 1024.
        settle();
        write_reg(CFG_WIDTH, 11'd3);
        write_reg(CFG_HEIGHT, 11'd1025);
        ramp_dx = 37;
        ramp_dy = 5;
        finish_frame(STYLE_RAMP);
        size_settings++;

        // Random frames, mostly small. Some get a size change mid-frame:
        // width never grows there, so no row history is read unwritten.
        rand_start = pix_count;
        while (pix_count - rand_start < RAND_PIXELS)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            style        = pix_style_t'($urandom_range(0, 3));
            sender_quiet = ($urandom_range(0, 3) == 0);
            ramp_dx      = $urandom_range(0, 80);
            ramp_dy      = $urandom_range(0, 80);
            settle();
            write_reg(CFG_WIDTH, raw_dim(w));
            write_reg(CFG_HEIGHT, raw_dim(h));
            size_settings++;
            if ($urandom_range(0, 5) == 0)
            begin
                stream_pixels($urandom_range(1, w * h - 1), style);
                settle();
                // counters keep running; one at or past the new limit wraps on next advance
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_WIDTH, raw_dim($urandom_range(3, w)));
                else
                    write_reg(CFG_HEIGHT, raw_dim($urandom_range(3, 10)));
                size_settings++;
                finish_frame(style);
            end
            else
            begin
                repeat ($urandom_range(1, 2)) finish_frame(style);
            end
        end

        sender_quiet = 1'b0;
        settle();

        $display("covered %0d pixels, %0d frames, %0d size settings (clamped, 1024 wide/tall,",
                 pix_count, frames_done, size_settings);
        $display("  mid-frame resizes); %0d edge results checked, input held %0d cycles",
                 results_seen, in_held);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sem_pkg.sv
hdl/sem_line_ram.sv
hdl/sem_window.sv
hdl/sem_mag.sv
hdl/sobel_edge_magnitude_3x3_top.sv
hdl/sem_checker.sv
bench/sobel_edge_magnitude_3x3_top_test.sv
